>>> rtl/nrt_pkg.sv
`default_nettype none
package nrt_pkg;

  localparam int unsigned IdW      = 24;
  localparam int unsigned RssiW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned EntryW   = IdW + RssiW + TimeW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_NEW       = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_WEAK      = 3'd3;
  localparam logic [2:0] ST_SELF      = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_PRUNED    = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_OWN_ID     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NEAR_THR   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAGIC      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RELAY_PCT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT    = 3'd4;

  localparam logic [1:0] PEER_ACTIVE = 2'd1;

  localparam logic signed [7:0] RSSI_STRONG = -8'sd55;
  localparam logic signed [7:0] RSSI_MID    = -8'sd65;
  localparam logic [7:0] ALPHA_STRONG = 8'd141;
  localparam logic [7:0] ALPHA_MID    = 8'd97;
  localparam logic [7:0] ALPHA_WEAK   = 8'd64;

  localparam logic [7:0] MIN_RELAY_BRIGHT = 8'd80;

  localparam logic signed [7:0]  NEAR_THR_RESET  = -8'sd70;
  localparam logic [6:0]         RELAY_PCT_RESET = 7'd30;
  localparam logic [31:0]        TIMEOUT_RESET   = 32'd10000;

endpackage
`default_nettype wire

>>> rtl/nrt_ram.sv
`default_nettype none
module nrt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/nrt_ema.sv
`default_nettype none
module nrt_ema (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic signed [7:0] prev_i,
  input  wire logic signed [7:0] raw_i,
  output logic signed [7:0]      smooth_o
);
  import nrt_pkg::*;

  logic [7:0]         alpha;
  logic signed [17:0] diff;
  logic signed [17:0] num_d;
  logic signed [17:0] num_q;
  logic signed [17:0] mag;
  logic signed [17:0] quo;
  logic signed [17:0] res;

  always_comb begin
    if (raw_i >= RSSI_STRONG) begin
      alpha = ALPHA_STRONG;
    end else if (raw_i >= RSSI_MID) begin
      alpha = ALPHA_MID;
    end else begin
      alpha = ALPHA_WEAK;
    end
    diff  = 18'(raw_i) - 18'(prev_i);
    num_d = (18'(prev_i) <<< 8) + $signed({10'd0, alpha}) * diff;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
    end
  end

  // Round to nearest with ties away from zero by working on the magnitude.
  always_comb begin
    mag      = num_q[17] ? -num_q : num_q;
    quo      = $signed((mag + 18'sd128) >>> 8);
    res      = num_q[17] ? -quo : quo;
    smooth_o = res[7:0];
  end

endmodule
`default_nettype wire

>>> rtl/neighbor_rssi_table.sv
`default_nettype none
// Neighbor table for radio adverts. An advert transaction is checked against the
// magic byte, the near threshold and the own id; a surviving advert walks the
// table one entry per cycle through a payload RAM with one read and one write
// port to find its peer or the lowest free entry. For a found peer it then
// smooths the RSSI in a multiply and round unit; a found or new entry is then
// written back. An advert thus updates an entry, claims a new entry or finds
// the table full; a dropped advert skips the walk, and a prune transaction
// walks the table and clears entries older than the timeout. Valid bits live
// in flip-flops and are cleared at reset, so no clearing pass is needed. The
// next input is taken once the result is registered, even while it still
// waits on the output side.
module neighbor_rssi_table #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nrt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [nrt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           in_func_i,
  input  wire logic [31:0]                    in_now_ms_i,
  input  wire logic [23:0]                    in_peer_id_i,
  input  wire logic [7:0]                     in_magic_i,
  input  wire logic signed [7:0]              in_rssi_i,
  input  wire logic [1:0]                     in_peer_state_i,
  input  wire logic [7:0]                     in_peer_brightness_i,
  input  wire logic                           in_lamp_listening_i,
  input  wire logic [6:0]                     in_rand_pct_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [2:0]                          out_status_o,
  output logic [2:0]                          out_slot_o,
  output logic signed [7:0]                   out_smoothed_rssi_o,
  output logic                                out_relay_fire_o,
  output logic [7:0]                          out_relay_brightness_o,
  output logic [3:0]                          out_removed_count_o
);
  import nrt_pkg::*;

  localparam int unsigned AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]              state_q;
  logic [23:0]             own_id_q;
  logic signed [7:0]       near_thr_q;
  logic [7:0]              magic_q;
  logic [6:0]              relay_pct_q;
  logic [31:0]             timeout_q;

  logic                    func_q;
  logic [31:0]             now_q;
  logic [23:0]             pid_q;
  logic signed [7:0]       rssi_q;
  logic [1:0]              pst_q;
  logic [7:0]              pbr_q;
  logic                    lis_q;
  logic [6:0]              rnd_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [CW-1:0]           cnt_q;
  logic                    rd_vld_q;
  logic [AW-1:0]           rd_idx_q;
  logic                    found_q;
  logic                    free_q;
  logic [AW-1:0]           found_idx_q;
  logic [AW-1:0]           free_idx_q;
  logic signed [7:0]       prev_q;
  logic [AW-1:0]           slot_q;
  logic signed [7:0]       sm_q;
  logic [2:0]              status_q;
  logic [CW-1:0]           removed_q;

  logic [EntryW-1:0]       rd_data;
  logic [23:0]             rd_pid;
  logic [31:0]             rd_last;
  logic signed [7:0]       rd_rssi;
  logic [31:0]             age;
  logic                    ram_we;
  logic signed [7:0]       ema_sm;
  logic                    accepted;
  logic                    fire;
  logic                    out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign ram_we     = (state_q == S_WR);
  assign rd_pid     = rd_data[EntryW-1 -: IdW];
  assign rd_rssi    = rd_data[TimeW +: RssiW];
  assign rd_last    = rd_data[TimeW-1:0];
  assign age        = now_q - rd_last;
  assign accepted   = (status_q == ST_NEW) || (status_q == ST_UPDATED);
  assign fire       = accepted && (pst_q == PEER_ACTIVE) && lis_q && (rnd_q < relay_pct_q);
  assign out_load   = (state_q == S_DONE) && (!out_valid_o || out_ready_i);

  nrt_ram #(
    .Width (EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({pid_q, sm_q, now_q}),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  nrt_ema u_ema (
    .clk_i    (clk_i),
    .en_i     (state_q == S_MUL),
    .prev_i   (prev_q),
    .raw_i    (rssi_q),
    .smooth_o (ema_sm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      near_thr_q  <= NEAR_THR_RESET;
      magic_q     <= '0;
      relay_pct_q <= RELAY_PCT_RESET;
      timeout_q   <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OWN_ID:    own_id_q    <= cfg_wdata_i[23:0];
        REG_NEAR_THR:  near_thr_q  <= $signed(cfg_wdata_i[7:0]);
        REG_MAGIC:     magic_q     <= cfg_wdata_i[7:0];
        REG_RELAY_PCT: relay_pct_q <= cfg_wdata_i[6:0];
        REG_TIMEOUT:   timeout_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
      prev_q      <= '0;
      slot_q      <= '0;
      sm_q        <= '0;
      status_q    <= ST_UPDATED;
      removed_q   <= '0;
      func_q      <= 1'b0;
      now_q       <= '0;
      pid_q       <= '0;
      rssi_q      <= '0;
      pst_q       <= '0;
      pbr_q       <= '0;
      lis_q       <= 1'b0;
      rnd_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q    <= in_func_i;
            now_q     <= in_now_ms_i;
            pid_q     <= in_peer_id_i;
            rssi_q    <= in_rssi_i;
            pst_q     <= in_peer_state_i;
            pbr_q     <= in_peer_brightness_i;
            lis_q     <= in_lamp_listening_i;
            rnd_q     <= in_rand_pct_i;
            cnt_q     <= '0;
            rd_vld_q  <= 1'b0;
            found_q   <= 1'b0;
            free_q    <= 1'b0;
            removed_q <= '0;
            if (in_func_i) begin
              status_q <= ST_PRUNED;
              state_q  <= S_SCAN;
            end else if (in_magic_i != magic_q) begin
              status_q <= ST_BAD_MAGIC;
              state_q  <= S_DONE;
            end else if (in_rssi_i < near_thr_q) begin
              status_q <= ST_WEAK;
              state_q  <= S_DONE;
            end else if (in_peer_id_i == own_id_q) begin
              status_q <= ST_SELF;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt_q < CW'(TABLE_ENTRIES)) begin
            cnt_q    <= cnt_q + CW'(1);
            rd_vld_q <= 1'b1;
            rd_idx_q <= cnt_q[AW-1:0];
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q) begin
            if (func_q) begin
              if (valid_q[rd_idx_q] && (age > timeout_q)) begin
                valid_q[rd_idx_q] <= 1'b0;
                removed_q         <= removed_q + CW'(1);
              end
            end else if (valid_q[rd_idx_q]) begin
              if (!found_q && (rd_pid == pid_q)) begin
                found_q     <= 1'b1;
                found_idx_q <= rd_idx_q;
                prev_q      <= rd_rssi;
              end
            end else if (!free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
            if (rd_idx_q == LastIdx) begin
              state_q <= S_DEC;
            end
          end
        end
        S_DEC: begin
          if (func_q) begin
            state_q <= S_DONE;
          end else if (found_q) begin
            slot_q   <= found_idx_q;
            status_q <= ST_UPDATED;
            state_q  <= S_MUL;
          end else if (free_q) begin
            slot_q   <= free_idx_q;
            sm_q     <= rssi_q;
            status_q <= ST_NEW;
            state_q  <= S_WR;
          end else begin
            status_q <= ST_FULL;
            state_q  <= S_DONE;
          end
        end
        S_MUL: begin
          state_q <= S_RND;
        end
        S_RND: begin
          sm_q    <= ema_sm;
          state_q <= S_WR;
        end
        S_WR: begin
          valid_q[slot_q] <= 1'b1;
          state_q         <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o            <= 1'b0;
      out_status_o           <= ST_UPDATED;
      out_slot_o             <= '0;
      out_smoothed_rssi_o    <= '0;
      out_relay_fire_o       <= 1'b0;
      out_relay_brightness_o <= '0;
      out_removed_count_o    <= '0;
    end else if (out_load) begin
      out_valid_o            <= 1'b1;
      out_status_o           <= status_q;
      out_slot_o             <= accepted ? 3'(slot_q) : 3'd0;
      out_smoothed_rssi_o    <= accepted ? sm_q : 8'sd0;
      out_relay_fire_o       <= fire;
      out_relay_brightness_o <= !fire ? 8'd0 :
                                (pbr_q < MIN_RELAY_BRIGHT) ? MIN_RELAY_BRIGHT : pbr_q;
      out_removed_count_o    <= (status_q == ST_PRUNED) ? 4'(removed_q) : 4'd0;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

endmodule
`default_nettype wire
